// ===== hdl/boi_pkg.sv =====
// Shared types and constants for the occurrence-table interleaver.
// Depends on nothing; every other file of the block imports it.
package boi_pkg;

  localparam int SYMS_PER_WORD        = 16;
  localparam int HALF_BITS            = 32;
  localparam int HIST_BITS            = 5;
  localparam int NUM_SYMBOLS          = 4;
  localparam int COUNT_BEATS          = 8;
  localparam int QUEUE_DEPTH          = 4;
  localparam int QUEUE_PTR_BITS       = $clog2(QUEUE_DEPTH);
  localparam int OCC_INTERVAL_DEFAULT = 128;
  localparam int COUNT_BITS_DEFAULT   = 64;

  localparam logic [2:0] LAST_COUNT_BEAT = 3'(COUNT_BEATS - 1);
  localparam logic       KIND_COUNT      = 1'b0;
  localparam logic       KIND_DATA       = 1'b1;

  typedef struct packed {
    logic [31:0] packed_word;
    logic [4:0]  valid_symbols;
    logic        final_word;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic        word_kind;
    logic        end_of_stream;
  } out_beat_t;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    logic [31:0]                                packed_word;
    logic                                       has_data;
    logic                                       open_interval;
    logic                                       last;
    logic [NUM_SYMBOLS-1:0][HIST_BITS-1:0]      hist;
  } job_t;

endpackage

// ===== hdl/bwt_occurrence_interleaver.sv =====
// Occurrence-table interleaver, top level.
// Input words are registered in the queue, output beats in the output register.
// Throughput: one output beat per cycle, set by the back-end sequencer, while the
// queue holds words and out_ready is high; an interval of W words gives W+8 beats.
// Synchronous reset (rst): counts, interval position, queue and out_valid clear.
// Depends on boi_pkg, boi_front, boi_queue and boi_back.
module bwt_occurrence_interleaver #(
  parameter int OCC_INTERVAL = boi_pkg::OCC_INTERVAL_DEFAULT,
  parameter int COUNT_BITS   = boi_pkg::COUNT_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  boi_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_ready,
  output boi_pkg::out_beat_t out_beat
);
  import boi_pkg::*;

  // The front end classifies each input beat: it builds a histogram of the
  // counted symbols and notes whether the word opens a new interval. Empty
  // words that are not final are dropped there, since they change nothing.
  logic push;
  job_t push_job;
  logic queue_full;

  // The queue decouples the two halves, so the front keeps taking words while
  // the back is busy writing an eight-beat count block, until the queue fills.
  logic pop;
  logic head_valid;
  job_t head;

  boi_front #(
    .OCC_INTERVAL(OCC_INTERVAL)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .push      (push),
    .push_job  (push_job),
    .queue_full(queue_full)
  );

  boi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  // The back end owns the running counts. For each queued word it writes the
  // interval counts if needed, then the data word if it has one (adding its histogram),
  // and for the final word the closing counts, after which the counts clear.
  boi_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

endmodule

// ===== hdl/boi_front.sv =====
// Front end: accepts input beats, counts the valid symbols of each word and marks
// interval starts. Depends on boi_pkg.
module boi_front #(
  parameter int OCC_INTERVAL = boi_pkg::OCC_INTERVAL_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  boi_pkg::in_beat_t in_beat,
  output logic              push,
  output boi_pkg::job_t     push_job,
  input  logic              queue_full
);
  import boi_pkg::*;

  localparam int WORDS    = (OCC_INTERVAL / SYMS_PER_WORD < 1) ? 1 : OCC_INTERVAL / SYMS_PER_WORD;
  localparam int WII_BITS = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [WII_BITS-1:0]                   word_in_interval;
  logic [WII_BITS-1:0]                   word_in_interval_next;
  logic [WII_BITS:0]                     wii_sum;
  logic [4:0]                            valid_clamped;
  logic                                  has_data;
  logic                                  accept;
  logic [NUM_SYMBOLS-1:0][HIST_BITS-1:0] hist;

  assign in_ready      = !queue_full;
  assign accept        = in_valid && in_ready;
  assign valid_clamped = (in_beat.valid_symbols > 5'(SYMS_PER_WORD)) ?
                         5'(SYMS_PER_WORD) : in_beat.valid_symbols;
  assign has_data      = (valid_clamped != 5'd0);

  // Per-symbol histogram of the counted leading symbols.
  always_comb begin
    logic [1:0] sym;
    hist = '0;
    for (int j = 0; j < SYMS_PER_WORD; j++) begin
      sym = in_beat.packed_word[31 - 2*j -: 2];
      if (5'(j) < valid_clamped) begin
        hist[sym] = hist[sym] + HIST_BITS'(1);
      end
    end
  end

  assign push_job.hist          = hist;
  assign push_job.packed_word   = in_beat.packed_word;
  assign push_job.has_data      = has_data;
  assign push_job.open_interval = has_data && (word_in_interval == '0);
  assign push_job.last          = in_beat.final_word;

  // Empty words that do not end the sequence leave no trace.
  assign push = accept && (has_data || in_beat.final_word);

  assign wii_sum = {1'b0, word_in_interval} + (WII_BITS+1)'(1);

  always_comb begin
    word_in_interval_next = word_in_interval;
    if (has_data) begin
      word_in_interval_next = (wii_sum >= (WII_BITS+1)'(WORDS)) ? '0 : wii_sum[WII_BITS-1:0];
    end
    if (in_beat.final_word) begin
      word_in_interval_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_in_interval <= '0;
    end else if (accept) begin
      word_in_interval <= word_in_interval_next;
    end
  end

endmodule

// ===== hdl/boi_queue.sv =====
// Small FIFO of classified words between the front and back ends.
// Depends on boi_pkg.
module boi_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  boi_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output boi_pkg::job_t head
);
  import boi_pkg::*;

  job_t                      entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   fill;
  logic                      do_pop;

  assign full       = (fill == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      end
      unique case ({push, do_pop})
        2'b10:   fill <= fill + (QUEUE_PTR_BITS+1)'(1);
        2'b01:   fill <= fill - (QUEUE_PTR_BITS+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hdl/boi_back.sv =====
// Back end: holds the running counts and sequences the output beats of each
// queued word (interval counts, data word, final counts). Depends on boi_pkg.
module boi_back #(
  parameter int COUNT_BITS = boi_pkg::COUNT_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  boi_pkg::job_t      head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output boi_pkg::out_beat_t out_beat
);
  import boi_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_INT  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_FIN  = 2'd3;

  logic [COUNT_BITS-1:0] counts [NUM_SYMBOLS];
  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [2:0]            beat_idx;
  logic [2:0]            beat_idx_next;
  logic [1:0]            phase;
  logic                  advance;
  logic                  fire;
  logic                  last_count_beat;
  logic [63:0]           count_sel;
  logic [31:0]           count_half;
  out_beat_t             beat;

  // In idle the head entry decides the first phase, so no bubble is lost.
  always_comb begin
    phase = state;
    if (state == PH_IDLE) begin
      if (!head_valid) begin
        phase = PH_IDLE;
      end else if (head.open_interval) begin
        phase = PH_INT;
      end else if (head.has_data) begin
        phase = PH_DATA;
      end else begin
        phase = PH_FIN;
      end
    end
  end

  assign advance         = !out_valid || out_ready;
  assign fire            = advance && (phase != PH_IDLE);
  assign last_count_beat = (beat_idx == LAST_COUNT_BEAT);

  assign count_sel  = 64'(counts[beat_idx[2:1]]);
  assign count_half = beat_idx[0] ? count_sel[63:32] : count_sel[31:0];

  always_comb begin
    beat.out_word      = count_half;
    beat.word_kind     = KIND_COUNT;
    beat.end_of_stream = (phase == PH_FIN) && last_count_beat;
    if (phase == PH_DATA) begin
      beat.out_word  = head.packed_word;
      beat.word_kind = KIND_DATA;
    end
  end

  always_comb begin
    state_next    = state;
    beat_idx_next = beat_idx;
    pop           = 1'b0;
    if (fire) begin
      unique case (phase)
        PH_INT: begin
          beat_idx_next = beat_idx + 3'd1;
          state_next    = PH_INT;
          if (last_count_beat) begin
            beat_idx_next = 3'd0;
            state_next    = PH_DATA;
          end
        end
        PH_DATA: begin
          beat_idx_next = 3'd0;
          if (head.last) begin
            state_next = PH_FIN;
          end else begin
            state_next = PH_IDLE;
            pop        = 1'b1;
          end
        end
        PH_FIN: begin
          beat_idx_next = beat_idx + 3'd1;
          state_next    = PH_FIN;
          if (last_count_beat) begin
            beat_idx_next = 3'd0;
            state_next    = PH_IDLE;
            pop           = 1'b1;
          end
        end
        default: begin
          state_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= PH_IDLE;
      beat_idx  <= 3'd0;
      out_valid <= 1'b0;
      for (int s = 0; s < NUM_SYMBOLS; s++) begin
        counts[s] <= '0;
      end
    end else if (advance) begin
      out_valid <= fire;
      state     <= state_next;
      beat_idx  <= beat_idx_next;
      if (fire && (phase == PH_DATA)) begin
        for (int s = 0; s < NUM_SYMBOLS; s++) begin
          counts[s] <= counts[s] + COUNT_BITS'(head.hist[s]);
        end
      end
      if (fire && (phase == PH_FIN) && last_count_beat) begin
        for (int s = 0; s < NUM_SYMBOLS; s++) begin
          counts[s] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_beat <= beat;
    end
  end

endmodule

// ===== test/tb_bwt_occurrence_interleaver.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bwt_occurrence_interleaver: scoreboard class plus driver tasks.
// Depends on boi_pkg and the bwt_occurrence_interleaver RTL; needs nothing else to run.

class interleave_scoreboard;
  logic [63:0]        tally [4];
  int unsigned        interval_pos;
  int unsigned        words_per_interval;
  logic [63:0]        tally_mask;
  boi_pkg::out_beat_t expected_beats [$];
  int unsigned        mismatches;
  int unsigned        count_beats;
  int unsigned        data_beats;

  function new(int interval_symbols, int count_bits);
    int bits;
    bits = (count_bits < 32) ? 32 : ((count_bits > 64) ? 64 : count_bits);
    words_per_interval = interval_symbols / boi_pkg::SYMS_PER_WORD;
    if (words_per_interval == 0) words_per_interval = 1;
    tally_mask   = {64{1'b1}} >> (64 - bits);
    mismatches   = 0;
    count_beats  = 0;
    data_beats   = 0;
    clear_sequence();
  endfunction

  function void clear_sequence();
    for (int s = 0; s < boi_pkg::NUM_SYMBOLS; s++) tally[s] = '0;
    interval_pos = 0;
  endfunction

  // Eight count beats: low half then high half for each symbol.
  function void queue_tallies(bit closing);
    logic [63:0]        c;
    boi_pkg::out_beat_t b;
    for (int s = 0; s < boi_pkg::NUM_SYMBOLS; s++) begin
      c = tally[s] & tally_mask;
      b.out_word      = c[31:0];
      b.word_kind     = boi_pkg::KIND_COUNT;
      b.end_of_stream = 1'b0;
      expected_beats.push_back(b);
      b.out_word      = c[63:32];
      b.end_of_stream = closing && (s == boi_pkg::NUM_SYMBOLS - 1);
      expected_beats.push_back(b);
    end
  endfunction

  function void absorb_word(boi_pkg::in_beat_t w);
    int unsigned        n;
    logic [1:0]         sym;
    boi_pkg::out_beat_t b;
    n = (w.valid_symbols > boi_pkg::SYMS_PER_WORD) ? boi_pkg::SYMS_PER_WORD : w.valid_symbols;
    if (n != 0) begin
      if (interval_pos == 0) queue_tallies(1'b0);
      b.out_word      = w.packed_word;
      b.word_kind     = boi_pkg::KIND_DATA;
      b.end_of_stream = 1'b0;
      expected_beats.push_back(b);
      for (int j = 0; j < n; j++) begin
        sym = 2'(w.packed_word >> (2 * (15 - j)));
        tally[sym] = (tally[sym] + 64'd1) & tally_mask;
      end
      interval_pos++;
      if (interval_pos >= words_per_interval) interval_pos = 0;
    end
    if (w.final_word) begin
      queue_tallies(1'b1);
      clear_sequence();
    end
  endfunction

  function void complain(string msg);
    mismatches++;
    $display("%0t: MISMATCH %s", $time, msg);
  endfunction

  function void check_beat(boi_pkg::out_beat_t got);
    boi_pkg::out_beat_t want;
    if (got.word_kind == boi_pkg::KIND_DATA) data_beats++;
    else count_beats++;
    if (expected_beats.size() == 0) begin
      complain($sformatf("unexpected beat, expected none, got %h", got));
      return;
    end
    want = expected_beats.pop_front();
    if (got.out_word != want.out_word)
      complain($sformatf("out_word expected %h, got %h", want.out_word, got.out_word));
    if (got.word_kind != want.word_kind)
      complain($sformatf("word_kind expected %b, got %b", want.word_kind, got.word_kind));
    if (got.end_of_stream != want.end_of_stream)
      complain($sformatf("end_of_stream expected %b, got %b",
                         want.end_of_stream, got.end_of_stream));
  endfunction

  function void finish_check();
    if (expected_beats.size() != 0)
      complain($sformatf("%0d expected beats never arrived, oldest expected %h, got none",
                         expected_beats.size(), expected_beats[0]));
  endfunction
endclass

module tb_bwt_occurrence_interleaver;

  // The block runs at its default sizes: 8 words per interval, 64-bit counts.
  localparam int OCC_INTERVAL = boi_pkg::OCC_INTERVAL_DEFAULT;
  localparam int COUNT_BITS   = boi_pkg::COUNT_BITS_DEFAULT;
  // Random stimulus stops once this many counted words have been accepted.
  localparam int WORD_TARGET  = 260;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  boi_pkg::in_beat_t  in_beat;
  logic               out_valid;
  logic               out_ready;
  boi_pkg::out_beat_t out_beat;

  interleave_scoreboard store;

  // When set, neither side inserts gaps, so back-to-back traffic is seen too.
  bit          calm;
  int unsigned words_offered;
  int unsigned sequences_offered;

  always #1 clk = ~clk;

  bwt_occurrence_interleaver #(
    .OCC_INTERVAL(OCC_INTERVAL),
    .COUNT_BITS  (COUNT_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_beat (out_beat)
  );

  // Gap lengths: mostly none or short, now and then a long pause.
  function automatic int idle_cycles();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // A quarter of the words repeat one symbol sixteen times, to pile up a single count.
  function automatic logic [31:0] random_word();
    logic [1:0] s;
    s = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) return {16{s}};
    return $urandom;
  endfunction

  // Present one input beat and hold it until the block takes it. Valid is only
  // lowered when a gap is wanted, so a back-to-back beat never toggles it within
  // one time step. The scoreboard learns of the beat at the accepting edge.
  task automatic send_word(input boi_pkg::in_beat_t w);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= w;
    do @(posedge clk); while (!in_ready);
    store.absorb_word(w);
  endtask

  task automatic offer(input logic [31:0] word, input int unsigned valid, input bit fin);
    boi_pkg::in_beat_t w;
    w.packed_word   = word;
    w.valid_symbols = 5'(valid);
    w.final_word    = fin;
    // Empty words that do not end a sequence are ignored by the block, so they do
    // not count toward the amount of stimulus.
    if (valid != 0 || fin) words_offered++;
    if (fin) sequences_offered++;
    send_word(w);
  endtask

  // Sequence of full words with random content; now and then a word carries a
  // random symbol count, which covers empty, short and oversized words mid-stream.
  task automatic well_formed_sequence(input int unsigned len);
    for (int unsigned i = 1; i < len; i++)
      offer(random_word(), ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : 16, 1'b0);
    offer(random_word(), $urandom_range(1, 16), 1'b1);
  endtask

  // Output side: ready runs in bursts with random stalls between them. A long
  // unbroken burst now and then lets the block run at full output rate.
  initial begin
    int span;
    int stall;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (span) @(posedge clk);
      stall = idle_cycles();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Every accepted output beat goes to the scoreboard. Sampling right after the
  // edge sees the values the block held at that edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) store.check_beat(out_beat);
  end

  initial begin
    int unsigned pick;
    rst               = 1'b1;
    in_valid          = 1'b0;
    in_beat           = '0;
    calm              = 1'b0;
    words_offered     = 0;
    sequences_offered = 0;
    store = new(OCC_INTERVAL, COUNT_BITS);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    // An empty sequence: only the final flag, so eight zero count beats come out.
    offer(32'hFFFF_FFFF, 0, 1'b1);
    // An empty word opening a sequence is dropped and does not open an interval.
    offer(32'h1234_5678, 0, 1'b0);
    // One symbol value per word, so each count moves on its own.
    offer(32'h0000_0000, 16, 1'b0);
    offer(32'hFFFF_FFFF, 16, 1'b0);
    offer(32'h5555_5555, 16, 1'b0);
    offer(32'hAAAA_AAAA, 16, 1'b0);
    // Symbol counts above sixteen are clipped to a full word.
    offer(32'h1B1B_1B1B, 31, 1'b0);
    offer(32'hE4E4_E4E4, 17, 1'b0);
    // A short word in mid-sequence counts only its leading symbol.
    offer(32'hC000_0000, 1, 1'b0);
    // An empty word in mid-sequence changes nothing.
    offer(32'hDEAD_BEEF, 0, 1'b0);
    // This is the eighth data word; the next one opens a new interval.
    offer(32'h0F0F_0F0F, 16, 1'b0);
    offer(32'hF0F0_F0F0, 16, 1'b0);
    offer(32'h36C9_36C9, 5, 1'b1);
    // An empty final word in mid-interval: final counts only, no data beat.
    offer(32'hA5A5_A5A5, 16, 1'b0);
    offer(32'h5A5A_5A5A, 0, 1'b1);
    // Single-word sequences: oversized and short final words.
    offer(32'h8765_4321, 20, 1'b1);
    offer(32'hFFFF_FFFF, 15, 1'b1);
    // Exactly one interval, ending on the last word of it.
    for (int i = 0; i < 7; i++) offer(random_word(), 16, 1'b0);
    offer(random_word(), 16, 1'b1);

    // Random part, one sequence at a time.
    while (words_offered < WORD_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        well_formed_sequence($urandom_range(1, 20));
      end else if (pick == 7) begin
        // Noise: arbitrary symbol counts on every word, the final one included.
        for (int unsigned i = $urandom_range(0, 11); i > 0; i--)
          offer(random_word(), $urandom_range(0, 31), 1'b0);
        offer(random_word(), $urandom_range(0, 31), 1'b1);
      end else if (pick == 8) begin
        // Empty words, then an empty or one-word sequence.
        for (int unsigned i = $urandom_range(0, 3); i > 0; i--) offer($urandom, 0, 1'b0);
        offer($urandom, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 31), 1'b1);
      end else begin
        // Several intervals in a row.
        well_formed_sequence($urandom_range(40, 70));
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain: every expected beat must show up, then a short quiet spell catches
    // any stray beat that follows.
    while (store.expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    store.finish_check();

    $display("Summary: %0d counted words in %0d sequences; %0d data beats and %0d count beats",
             words_offered, sequences_offered, store.data_beats, store.count_beats);
    $display("Summary: %0d mismatches found.", store.mismatches);
    if (store.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run (every word with its most beats,
  // every beat behind the longest stall).
  initial begin
    #2000000;
    $display("Timeout: the run did not finish in time.");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
